// File: hw/rtl/cmsb_pkg.sv
// Shared types and constants of the sprite row blitter.
`timescale 1ns / 1ps
`default_nettype none
package cmsb_pkg;

    localparam int LANES  = 16;
    localparam int ADDR_W = 15;
    localparam int BASE_W = 11;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_PIXEL_FORMAT = 2'd0;
    localparam logic [IDX_W-1:0] REG_WHITE_VALUE  = 2'd1;
    localparam logic [IDX_W-1:0] REG_BLACK_VALUE  = 2'd2;

    localparam logic FMT_PACKED = 1'b0;
    localparam logic FMT_BYTE   = 1'b1;

    localparam logic [7:0] WHITE_RESET = 8'hFF;
    localparam logic [7:0] BLACK_RESET = 8'hC0;

    // What one lane finds about its column.
    typedef struct packed {
        logic       vis;
        logic       slot;
        logic [3:0] bitpos;
    } lane_t;

    // Merged view of one row: pixels or words still to write.
    typedef struct packed {
        logic [LANES-1:0] pend;
        logic [15:0]      en0;
        logic [15:0]      en1;
        logic [15:0]      data0;
        logic [15:0]      data1;
    } job_t;

endpackage
`default_nettype wire

// File: hw/rtl/cmsb_if.sv
// Valid/ready channels for sprite rows and framebuffer writes.
`timescale 1ns / 1ps
`default_nettype none
interface cmsb_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic [3:0]         row_number;
    logic [15:0]        row_bits;
    logic [15:0]        mask_bits;
    logic               sprite_size;
    logic               use_mask;

    modport source (output valid, pos_x, pos_y, row_number, row_bits, mask_bits,
                    sprite_size, use_mask, input ready);
    modport sink (input valid, pos_x, pos_y, row_number, row_bits, mask_bits,
                  sprite_size, use_mask, output ready);
endinterface

interface cmsb_out_if;
    logic        valid;
    logic        ready;
    logic [14:0] write_address;
    logic [15:0] write_data;
    logic [15:0] write_enable;
    logic        last;

    modport source (output valid, write_address, write_data, write_enable, last,
                    input ready);
    modport sink (input valid, write_address, write_data, write_enable, last,
                  output ready);
endinterface
`default_nettype wire

// File: hw/rtl/cmsb_lane.sv
// One pixel column lane: clip test and packed word position.
`timescale 1ns / 1ps
`default_nettype none
module cmsb_lane #(
    parameter int LANE         = 0,
    parameter int SCREEN_WIDTH = 144
) (
    input  wire logic signed [15:0] pos_x,
    input  wire logic               sprite_size,
    input  wire logic               use_mask,
    input  wire logic               mask_bit,
    output cmsb_pkg::lane_t         result
);

    logic [16:0] col;
    logic        lane_on;
    logic        base_lsb;

    assign col      = {pos_x[15], pos_x} + 17'(LANE);
    assign lane_on  = ((LANE < 8) || sprite_size) && (!use_mask || mask_bit);
    // low bit of the first word touched, taken from the clipped left edge
    assign base_lsb = pos_x[15] ? 1'b0 : pos_x[4];

    assign result.vis    = lane_on && !col[16] && (col[15:0] < 16'(SCREEN_WIDTH));
    assign result.slot   = col[4] ^ base_lsb;
    assign result.bitpos = col[3:0];

endmodule
`default_nettype wire

// File: hw/rtl/cmsb_merge.sv
// Merge stage: combine lane results into packed words or a pixel list.
`timescale 1ns / 1ps
`default_nettype none
module cmsb_merge (
    input  wire cmsb_pkg::lane_t [cmsb_pkg::LANES-1:0] lanes,
    input  wire logic [15:0]                           row_bits,
    input  wire logic                                  fmt,
    input  wire logic                                  row_ok,
    output cmsb_pkg::job_t                             job
);

    logic [15:0]                en0;
    logic [15:0]                en1;
    logic [15:0]                data0;
    logic [15:0]                data1;
    logic [cmsb_pkg::LANES-1:0] vis;

    always_comb
    begin
        en0   = '0;
        en1   = '0;
        data0 = '0;
        data1 = '0;
        vis   = '0;
        for (int i = 0; i < cmsb_pkg::LANES; i++)
        begin
            vis[i] = lanes[i].vis;
            if (lanes[i].vis)
            begin
                if (lanes[i].slot)
                begin
                    en1[lanes[i].bitpos]   = 1'b1;
                    data1[lanes[i].bitpos] = row_bits[i];
                end
                else
                begin
                    en0[lanes[i].bitpos]   = 1'b1;
                    data0[lanes[i].bitpos] = row_bits[i];
                end
            end
        end
    end

    always_comb
    begin
        job.en0   = en0;
        job.en1   = en1;
        job.data0 = data0;
        job.data1 = data1;
        if (!row_ok)
            job.pend = '0;
        else if (fmt == cmsb_pkg::FMT_BYTE)
            job.pend = vis;
        else
            job.pend = {{(cmsb_pkg::LANES-2){1'b0}}, |en1, |en0};
    end

endmodule
`default_nettype wire

// File: hw/rtl/clipped_masked_sprite_row_blit.sv
// Top level: clipped, masked sprite row to framebuffer write converter.
//
// Channel row (sink) takes one sprite row per word: position, row number,
// pixel and mask bits. Channel wr (source) gives framebuffer writes, with
// last set on the final write of a row. The config port writes pixel_format,
// white_value and black_value; write it only while no row is in flight.
// Sixteen lanes clip every column of the row in the accept cycle and a merge
// stage folds them into a job register. An emitter takes one pending pixel
// (byte mode) or one word (packed mode) per cycle into the output register
// while wr does not stall. A first write passes the job register, then the
// output register. A row gives at most 16 writes in byte mode and 2 in
// packed mode; a row that writes nothing gives no write at all.
// The next row is taken in the cycle the emitter hands out the last write.
// When wr stalls, the output register holds its word and the emitter waits.
// Reset clears the job and output valid and loads the register defaults.
`timescale 1ns / 1ps
`default_nettype none
module clipped_masked_sprite_row_blit #(
    parameter int SCREEN_WIDTH   = 144,
    parameter int SCREEN_HEIGHT  = 168,
    parameter int WORDS_PER_LINE = 10
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         cfg_write_enable,
    input  wire logic [cmsb_pkg::IDX_W-1:0]   cfg_index,
    input  wire logic [7:0]                   cfg_data,
    cmsb_in_if.sink                           row,
    cmsb_out_if.source                        wr
);

    localparam int LINE_W = $clog2(SCREEN_HEIGHT);
    localparam int AW     = cmsb_pkg::ADDR_W;

    logic       fmt_cfg_reg;
    logic [7:0] white_reg;
    logic [7:0] black_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_cfg_reg <= cmsb_pkg::FMT_PACKED;
            white_reg   <= cmsb_pkg::WHITE_RESET;
            black_reg   <= cmsb_pkg::BLACK_RESET;
        end
        else if (cfg_write_enable)
        begin
            case (cfg_index)
                cmsb_pkg::REG_PIXEL_FORMAT: fmt_cfg_reg <= cfg_data[0];
                cmsb_pkg::REG_WHITE_VALUE:  white_reg   <= cfg_data;
                cmsb_pkg::REG_BLACK_VALUE:  black_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    // lanes and merge
    cmsb_pkg::lane_t [cmsb_pkg::LANES-1:0] lanes;
    cmsb_pkg::job_t                        job;

    for (genvar g = 0; g < cmsb_pkg::LANES; g++)
    begin : g_lane
        cmsb_lane #(
            .LANE         (g),
            .SCREEN_WIDTH (SCREEN_WIDTH)
        ) u_lane (
            .pos_x       (row.pos_x),
            .sprite_size (row.sprite_size),
            .use_mask    (row.use_mask),
            .mask_bit    (row.mask_bits[g]),
            .result      (lanes[g])
        );
    end

    logic [16:0] screen_y;
    logic        row_ok;

    assign screen_y = {row.pos_y[15], row.pos_y} + 17'(row.row_number);
    assign row_ok   = (row.sprite_size || !row.row_number[3]) && !screen_y[16]
                      && (screen_y[15:0] < 16'(SCREEN_HEIGHT));

    cmsb_merge u_merge (
        .lanes    (lanes),
        .row_bits (row.row_bits),
        .fmt      (fmt_cfg_reg),
        .row_ok   (row_ok),
        .job      (job)
    );

    // job register
    logic [cmsb_pkg::LANES-1:0]  pend_reg;
    logic                        fmt_reg;
    logic [LINE_W-1:0]           line_reg;
    logic [AW-1:0]               px_reg;
    logic [cmsb_pkg::BASE_W-1:0] base_reg;
    logic [15:0]                 bits_reg;
    logic [15:0]                 en0_reg;
    logic [15:0]                 en1_reg;
    logic [15:0]                 data0_reg;
    logic [15:0]                 data1_reg;

    logic [3:0]                  sel;
    logic [cmsb_pkg::LANES-1:0]  pend_clr;
    logic                        adv;
    logic                        accept;

    logic        out_valid_reg;
    logic [AW-1:0] out_addr_reg;
    logic [15:0] out_data_reg;
    logic [15:0] out_en_reg;
    logic        out_last_reg;

    always_comb
    begin
        sel = '0;
        for (int i = cmsb_pkg::LANES - 1; i >= 0; i--)
        begin
            if (pend_reg[i])
                sel = 4'(i);
        end
    end

    assign pend_clr  = pend_reg & ~(cmsb_pkg::LANES'(1) << sel);
    assign adv       = (|pend_reg) && (!out_valid_reg || wr.ready);
    assign row.ready = !(|pend_reg) || (adv && !(|pend_clr));
    assign accept    = row.valid && row.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pend_reg <= '0;
        else if (accept)
            pend_reg <= job.pend;
        else if (adv)
            pend_reg <= pend_clr;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            fmt_reg   <= fmt_cfg_reg;
            line_reg  <= screen_y[LINE_W-1:0];
            px_reg    <= row.pos_x[AW-1:0];
            base_reg  <= row.pos_x[15] ? '0 : row.pos_x[14:4];
            bits_reg  <= row.row_bits;
            en0_reg   <= job.en0;
            en1_reg   <= job.en1;
            data0_reg <= job.data0;
            data1_reg <= job.data1;
        end
    end

    // emitter: one write per cycle into the output register, unless wr stalls
    logic [AW-1:0] line_ext;
    logic [AW-1:0] addr_next;
    logic [15:0]   data_next;
    logic [15:0]   en_next;

    assign line_ext = AW'(line_reg);

    always_comb
    begin
        if (fmt_reg == cmsb_pkg::FMT_BYTE)
        begin
            addr_next = AW'(line_ext * AW'(SCREEN_WIDTH)) + px_reg + AW'(sel);
            data_next = {8'h00, bits_reg[sel] ? white_reg : black_reg};
            en_next   = '1;
        end
        else
        begin
            addr_next = AW'(line_ext * AW'(WORDS_PER_LINE)) + AW'(base_reg) + AW'(sel);
            data_next = sel[0] ? data1_reg : data0_reg;
            en_next   = sel[0] ? en1_reg : en0_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= 1'b1;
        else if (wr.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_addr_reg <= addr_next;
            out_data_reg <= data_next;
            out_en_reg   <= en_next;
            out_last_reg <= !(|pend_clr);
        end
    end

    assign wr.valid         = out_valid_reg;
    assign wr.write_address = out_addr_reg;
    assign wr.write_data    = out_data_reg;
    assign wr.write_enable  = out_en_reg;
    assign wr.last          = out_last_reg;

    // packed rows never hold more than two words
    a_packed_two_words: assert property (@(posedge clk) disable iff (!rst_n)
        (fmt_reg == cmsb_pkg::FMT_PACKED) |-> (pend_reg[cmsb_pkg::LANES-1:2] == '0))
        else $error("packed job holds more than two words");

    // a write that is not last leaves work in the job register
    a_more_after_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !out_last_reg) |-> (pend_reg != '0))
        else $error("non-last write with empty job");

    // every write changes at least one bit
    a_enable_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_en_reg != '0))
        else $error("write with no enabled bit");

    // the emitter never stalls when the output side can take a word
    a_emit_progress: assert property (@(posedge clk) disable iff (!rst_n)
        ((pend_reg != '0) && !out_valid_reg) |=> out_valid_reg)
        else $error("emitter idle with pending work");

endmodule
`default_nettype wire
